// ===== rtl/msp_pkg.sv =====
// Shared types and constants for the MIDI sysex chunk parser.
// Used by msp_decode and midi_sysex_chunk_parser; depends on nothing.
package msp_pkg;

    localparam int STEP_CHUNK_BYTES = 7;
    localparam int COUNT_W          = 3;
    localparam int DATA_W           = 7;
    localparam int BYTE_W           = 8;
    localparam int CFG_IDX_W        = 2;

    localparam logic [BYTE_W-1:0] STATUS_FLAG      = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_MASK        = 8'hff;
    localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'hf0;

    localparam logic [CFG_IDX_W-1:0] REG_SYSEX_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd1;

    typedef enum logic [1:0] {
        KIND_MSG,
        KIND_STEP,
        KIND_PATTERN,
        KIND_MAIN
    } kind_t;

    typedef enum logic [1:0] {
        MODE_DROP,
        MODE_STEP,
        MODE_PATTERN,
        MODE_MAIN
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  running_status;
        logic [COUNT_W-1:0] byte_count;
        logic [DATA_W-1:0]  held_first_data;
    } parse_state_t;

    typedef struct packed {
        logic               we;
        logic [COUNT_W-1:0] addr;
        logic [DATA_W-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        kind_t                                     kind;
        logic [BYTE_W-1:0]                         status;
        logic [DATA_W-1:0]                         first_data;
        logic [DATA_W-1:0]                         second_data;
        logic [STEP_CHUNK_BYTES-1:0][BYTE_W-1:0]   chunk;
    } result_t;

endpackage

// ===== rtl/msp_decode.sv =====
// Byte decoder: next parse state, chunk store write and result for one byte.
// Depends on msp_pkg.
module msp_decode
(
    input  logic [msp_pkg::BYTE_W-1:0]                               rx_byte,
    input  msp_pkg::mode_t                                           sysex_mode,
    input  logic [msp_pkg::BYTE_W-1:0]                               start_code,
    input  msp_pkg::parse_state_t                                    state,
    input  logic [msp_pkg::STEP_CHUNK_BYTES-1:0][msp_pkg::DATA_W-1:0] store,
    output msp_pkg::parse_state_t                                    state_next,
    output msp_pkg::store_wr_t                                       store_wr,
    output logic                                                     res_valid,
    output msp_pkg::result_t                                         res
);

    logic [msp_pkg::DATA_W-1:0] d;

    assign d = rx_byte[msp_pkg::DATA_W-1:0];

    always_comb
    begin
        state_next = state;
        store_wr   = '0;
        res_valid  = 1'b0;
        res        = '0;
        res.status = state.running_status;

        if ((rx_byte & msp_pkg::STATUS_FLAG) != '0)
        begin
            state_next.running_status = rx_byte & msp_pkg::BYTE_MASK;
            state_next.byte_count     = '0;
        end
        else if (state.running_status == start_code)
        begin
            case (sysex_mode)
                msp_pkg::MODE_STEP:
                begin
                    if (state.byte_count < msp_pkg::COUNT_W'(msp_pkg::STEP_CHUNK_BYTES))
                    begin
                        store_wr.we           = 1'b1;
                        store_wr.addr         = state.byte_count;
                        store_wr.data         = d;
                        state_next.byte_count = state.byte_count + 3'd1;
                    end
                    else
                    begin
                        // put back bit 7 of each stored byte
                        for (int i = 0; i < msp_pkg::STEP_CHUNK_BYTES; i++)
                        begin
                            res.chunk[i] = {d[i], store[i]};
                        end
                        res.kind              = msp_pkg::KIND_STEP;
                        res_valid             = 1'b1;
                        state_next.byte_count = '0;
                    end
                end
                msp_pkg::MODE_PATTERN:
                begin
                    store_wr.we   = 1'b1;
                    store_wr.data = d;
                    if (state.byte_count == '0)
                    begin
                        store_wr.addr         = 3'd0;
                        state_next.byte_count = 3'd1;
                    end
                    else
                    begin
                        store_wr.addr         = 3'd1;
                        res.chunk[0]          = {1'b0, store[0]};
                        res.chunk[1]          = {1'b0, d};
                        res.kind              = msp_pkg::KIND_PATTERN;
                        res_valid             = 1'b1;
                        state_next.byte_count = '0;
                    end
                end
                msp_pkg::MODE_MAIN:
                begin
                    store_wr.we   = 1'b1;
                    store_wr.data = d;
                    if (state.byte_count < 3'd2)
                    begin
                        store_wr.addr         = {2'b00, state.byte_count[0]};
                        state_next.byte_count = state.byte_count + 3'd1;
                    end
                    else
                    begin
                        // pack 7+7+2 bits into one 16-bit word, split high/low
                        store_wr.addr         = 3'd2;
                        res.chunk[0]          = {d[1:0], store[1][6:1]};
                        res.chunk[1]          = {store[1][0], store[0]};
                        res.kind              = msp_pkg::KIND_MAIN;
                        res_valid             = 1'b1;
                        state_next.byte_count = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state.byte_count == '0)
        begin
            state_next.held_first_data = d;
            state_next.byte_count      = 3'd1;
        end
        else
        begin
            res.kind              = msp_pkg::KIND_MSG;
            res.first_data        = state.held_first_data;
            res.second_data       = d;
            res_valid             = 1'b1;
            state_next.byte_count = '0;
        end
    end

endmodule

// ===== rtl/midi_sysex_chunk_parser.sv =====
// MIDI parser with sysex chunk unpacking: registers, handshakes, chunk store.
// Depends on msp_pkg and msp_decode.
//
// Takes one received byte per clock cycle and gives at most one result per
// byte, registered, in the cycle after the completing byte is accepted.
// All decoding of a byte is short combinational logic from the input port
// into the state and the output register, so in_ready stays high unless a
// result is waiting and out_ready is low. Status bytes set the running
// status; two-data messages, 7+1 byte step chunks, pattern pairs and packed
// main step words come out under their result_kind. Configuration writes are
// taken in every cycle; a write to sysex_mode clears any partial chunk.
module midi_sysex_chunk_parser
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msp_pkg::BYTE_W-1:0]         cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [msp_pkg::BYTE_W-1:0]         rx_byte,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         result_kind,
    output logic [msp_pkg::BYTE_W-1:0]         msg_status,
    output logic [msp_pkg::DATA_W-1:0]         first_data,
    output logic [msp_pkg::DATA_W-1:0]         second_data,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte0,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte1,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte2,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte3,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte4,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte5,
    output logic [msp_pkg::BYTE_W-1:0]         chunk_byte6
);

    msp_pkg::mode_t                 mode_reg;
    msp_pkg::mode_t                 mode_next;
    logic [msp_pkg::BYTE_W-1:0]     start_code_reg;
    logic [msp_pkg::BYTE_W-1:0]     start_code_next;
    msp_pkg::parse_state_t          state_reg;
    msp_pkg::parse_state_t          state_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    msp_pkg::result_t               result_reg;

    logic [msp_pkg::STEP_CHUNK_BYTES-1:0][msp_pkg::DATA_W-1:0] chunk_store_reg;

    msp_pkg::parse_state_t          dec_state;
    msp_pkg::store_wr_t             dec_wr;
    logic                           dec_valid;
    msp_pkg::result_t               dec_res;

    logic                           in_fire;
    logic                           cfg_fire;
    logic                           mode_wr;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign mode_wr   = cfg_fire && (cfg_index == msp_pkg::REG_SYSEX_MODE);
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    msp_decode u_decode
    (
        .rx_byte    (rx_byte),
        .sysex_mode (mode_reg),
        .start_code (start_code_reg),
        .state      (state_reg),
        .store      (chunk_store_reg),
        .state_next (dec_state),
        .store_wr   (dec_wr),
        .res_valid  (dec_valid),
        .res        (dec_res)
    );

    always_comb
    begin
        mode_next       = mode_reg;
        start_code_next = start_code_reg;
        state_next      = state_reg;
        if (in_fire)
        begin
            state_next = dec_state;
        end
        if (cfg_fire)
        begin
            case (cfg_index)
                msp_pkg::REG_SYSEX_MODE:
                begin
                    mode_next             = msp_pkg::mode_t'(cfg_data[1:0]);
                    state_next.byte_count = '0;
                end
                msp_pkg::REG_START_CODE:
                begin
                    start_code_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
        out_valid_next = (in_fire && dec_valid) || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= msp_pkg::MODE_DROP;
            start_code_reg <= msp_pkg::START_CODE_RESET;
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            start_code_reg <= start_code_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && dec_valid)
        begin
            result_reg <= dec_res;
        end
        if (in_fire && dec_wr.we)
        begin
            chunk_store_reg[dec_wr.addr] <= dec_wr.data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_reg.kind;
    assign msg_status  = result_reg.status;
    assign first_data  = result_reg.first_data;
    assign second_data = result_reg.second_data;
    assign chunk_byte0 = result_reg.chunk[0];
    assign chunk_byte1 = result_reg.chunk[1];
    assign chunk_byte2 = result_reg.chunk[2];
    assign chunk_byte3 = result_reg.chunk[3];
    assign chunk_byte4 = result_reg.chunk[4];
    assign chunk_byte5 = result_reg.chunk[5];
    assign chunk_byte6 = result_reg.chunk[6];

    a_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.running_status[7] || (state_reg.running_status == '0))
        else $error("running status holds a data byte");

    a_status_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rx_byte[7]) |=> (state_reg.byte_count == '0))
        else $error("status byte did not clear byte count");

    a_status_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rx_byte[7] && out_ready) |=> !out_valid)
        else $error("status byte produced a result");

    a_mode_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_wr |=> (state_reg.byte_count == '0))
        else $error("mode write left a partial chunk");

endmodule

// ===== tb/sv/midi_sysex_chunk_parser_tb.sv =====
// Self-checking testbench for midi_sysex_chunk_parser: directed and random byte streams,
// random idling on the byte input and the result output, and a built-in parser that predicts every result.
// Depends on msp_pkg and the midi_sysex_chunk_parser RTL.
`timescale 1ns / 1ps

module midi_sysex_chunk_parser_tb;

    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 4;

    localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        logic [msp_pkg::CFG_IDX_W-1:0] idx;
        logic [msp_pkg::BYTE_W-1:0]    data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [msp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [msp_pkg::BYTE_W-1:0]    cfg_data = '0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [msp_pkg::BYTE_W-1:0]    rx_byte = '0;

    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [1:0]                    result_kind;
    logic [msp_pkg::BYTE_W-1:0]    msg_status;
    logic [msp_pkg::DATA_W-1:0]    first_data;
    logic [msp_pkg::DATA_W-1:0]    second_data;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte0;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte1;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte2;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte3;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte4;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte5;
    logic [msp_pkg::BYTE_W-1:0]    chunk_byte6;

    midi_sysex_chunk_parser u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .msg_status  (msg_status),
        .first_data  (first_data),
        .second_data (second_data),
        .chunk_byte0 (chunk_byte0),
        .chunk_byte1 (chunk_byte1),
        .chunk_byte2 (chunk_byte2),
        .chunk_byte3 (chunk_byte3),
        .chunk_byte4 (chunk_byte4),
        .chunk_byte5 (chunk_byte5),
        .chunk_byte6 (chunk_byte6)
    );

    // parser shadow state and registers
    msp_pkg::mode_t             cfg_mode  = msp_pkg::MODE_DROP;
    logic [msp_pkg::BYTE_W-1:0] cfg_start = msp_pkg::START_CODE_RESET;
    logic [msp_pkg::BYTE_W-1:0] run_status = '0;
    logic [msp_pkg::COUNT_W-1:0] fill_count = '0;
    logic [msp_pkg::DATA_W-1:0] held_data = '0;
    logic [msp_pkg::DATA_W-1:0] chunk_mem [msp_pkg::STEP_CHUNK_BYTES];

    msp_pkg::result_t           parsed_q [$];
    logic [msp_pkg::BYTE_W-1:0] rx_q [$];
    reg_write_t                 reg_write_q [$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned writes_queued = 0;
    int unsigned writes_taken = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned send_burst = 0;
    int unsigned stall_left = 0;
    int unsigned stall_burst = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned next_gap(input bit no_gap);
        int unsigned r;
        r = $urandom_range(99);
        if (no_gap || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [msp_pkg::DATA_W-1:0] rand_data();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 7'h7f;
        return 7'($urandom_range(127));
    endfunction

    function automatic logic [msp_pkg::BYTE_W-1:0] pick_start_code();
        case ($urandom_range(4))
            0:       return msp_pkg::STATUS_FLAG;
            1:       return msp_pkg::BYTE_MASK;
            2:       return msp_pkg::START_CODE_RESET;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [msp_pkg::BYTE_W-1:0] got,
                                   input logic [msp_pkg::BYTE_W-1:0] want);
        if (error_count < 50)
            $display("MISMATCH %s: got %0h expected %0h at cycle %0d",
                     what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic apply_reg_write(input logic [msp_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [msp_pkg::BYTE_W-1:0] data);
        if (idx == msp_pkg::REG_SYSEX_MODE)
        begin
            cfg_mode   = msp_pkg::mode_t'(data[1:0]);
            fill_count = '0;
        end
        else if (idx == msp_pkg::REG_START_CODE)
        begin
            cfg_start = data;
        end
    endtask

    task automatic parse_rx_byte(input logic [msp_pkg::BYTE_W-1:0] b);
        logic [msp_pkg::DATA_W-1:0] d;
        logic [15:0]                word;
        msp_pkg::result_t           r;
        bit                         give;
        d    = b[msp_pkg::DATA_W-1:0];
        r    = '0;
        give = 1'b0;
        if (b[7])
        begin
            run_status = b;
            fill_count = '0;
        end
        else if (run_status == cfg_start)
        begin
            case (cfg_mode)
                msp_pkg::MODE_STEP:
                begin
                    if (fill_count < msp_pkg::COUNT_W'(msp_pkg::STEP_CHUNK_BYTES))
                    begin
                        chunk_mem[fill_count] = d;
                        fill_count++;
                    end
                    else
                    begin
                        for (int i = 0; i < msp_pkg::STEP_CHUNK_BYTES; i++)
                            r.chunk[i] = {d[i], chunk_mem[i]};
                        r.kind     = msp_pkg::KIND_STEP;
                        give       = 1'b1;
                        fill_count = '0;
                    end
                end
                msp_pkg::MODE_PATTERN:
                begin
                    if (fill_count == '0)
                    begin
                        chunk_mem[0] = d;
                        fill_count   = 3'd1;
                    end
                    else
                    begin
                        chunk_mem[1] = d;
                        r.chunk[0]   = {1'b0, chunk_mem[0]};
                        r.chunk[1]   = {1'b0, d};
                        r.kind       = msp_pkg::KIND_PATTERN;
                        give         = 1'b1;
                        fill_count   = '0;
                    end
                end
                msp_pkg::MODE_MAIN:
                begin
                    if (fill_count < 3'd2)
                    begin
                        chunk_mem[fill_count[0]] = d;
                        fill_count++;
                    end
                    else
                    begin
                        chunk_mem[2] = d;
                        word         = {d[1:0], chunk_mem[1], chunk_mem[0]};
                        r.chunk[0]   = word[15:8];
                        r.chunk[1]   = word[7:0];
                        r.kind       = msp_pkg::KIND_MAIN;
                        give         = 1'b1;
                        fill_count   = '0;
                    end
                end
                default: ;
            endcase
        end
        else if (fill_count == '0)
        begin
            held_data  = d;
            fill_count = 3'd1;
        end
        else
        begin
            r.kind        = msp_pkg::KIND_MSG;
            r.first_data  = held_data;
            r.second_data = d;
            give          = 1'b1;
            fill_count    = '0;
        end
        if (give)
        begin
            r.status = run_status;
            parsed_q.push_back(r);
        end
    endtask

    task automatic check_result();
        msp_pkg::result_t           want;
        logic [msp_pkg::BYTE_W-1:0] got_chunk [msp_pkg::STEP_CHUNK_BYTES];
        got_chunk = '{chunk_byte0, chunk_byte1, chunk_byte2, chunk_byte3,
                      chunk_byte4, chunk_byte5, chunk_byte6};
        if (parsed_q.size() == 0)
        begin
            report_mismatch("result with none pending", {6'd0, result_kind}, '0);
            return;
        end
        want = parsed_q.pop_front();
        if (result_kind !== want.kind)
            report_mismatch("result_kind", {6'd0, result_kind}, {6'd0, want.kind});
        if (msg_status !== want.status)
            report_mismatch("msg_status", msg_status, want.status);
        if (first_data !== want.first_data)
            report_mismatch("first_data", {1'b0, first_data}, {1'b0, want.first_data});
        if (second_data !== want.second_data)
            report_mismatch("second_data", {1'b0, second_data}, {1'b0, want.second_data});
        for (int i = 0; i < msp_pkg::STEP_CHUNK_BYTES; i++)
            if (got_chunk[i] !== want.chunk[i])
                report_mismatch($sformatf("chunk_byte%0d", i), got_chunk[i], want.chunk[i]);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // observe handshakes and track the parser
    always @(posedge clk)
    begin
        in_taken  <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write(cfg_index, cfg_data);
                writes_taken++;
            end
            if (in_valid && in_ready)
            begin
                parse_rx_byte(rx_byte);
                bytes_taken++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (rx_q.size() > 0)
            begin
                in_valid <= 1'b1;
                rx_byte  <= rx_q.pop_front();
                send_gap = next_gap(send_burst != 0);
                if (send_burst != 0)
                    send_burst--;
                else if ($urandom_range(63) == 0)
                    send_burst = $urandom_range(16, 64);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(cfg_valid && !cfg_taken))
        begin
            if (reg_write_q.size() > 0)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= reg_write_q[0].idx;
                cfg_data  <= reg_write_q[0].data;
                void'(reg_write_q.pop_front());
            end
            else
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = next_gap(stall_burst != 0);
            if (stall_burst != 0)
                stall_burst--;
            else if ($urandom_range(63) == 0)
                stall_burst = $urandom_range(16, 64);
        end
    end

    task automatic send_byte(input logic [msp_pkg::BYTE_W-1:0] b);
        rx_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic write_reg(input logic [msp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [msp_pkg::BYTE_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_write_q.push_back(w);
        writes_queued++;
        while (writes_taken != writes_queued)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || parsed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_sequence();
        int unsigned                pick;
        int unsigned                n;
        int unsigned                len;
        logic [msp_pkg::BYTE_W-1:0] status;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            case (cfg_mode)
                msp_pkg::MODE_STEP:    len = msp_pkg::STEP_CHUNK_BYTES + 1;
                msp_pkg::MODE_PATTERN: len = 2;
                default:               len = 3;
            endcase
            send_byte(cfg_start);
            n = len * $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                send_byte({1'b0, rand_data()});
        end
        else if (pick < 80)
        begin
            status = 8'($urandom_range(8'h80, 8'hff));
            send_byte(status);
            n = 2 * $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                send_byte({1'b0, rand_data()});
        end
        else if (pick < 90)
        begin
            status = $urandom_range(1) ? cfg_start : 8'($urandom_range(8'h80, 8'hff));
            send_byte(status);
            n = $urandom_range(0, 9);
            for (int i = 0; i < n; i++)
                send_byte({1'b0, rand_data()});
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int unsigned random_base;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // start code zero matches the reset running status: plain data opens a step chunk
        write_reg(msp_pkg::REG_START_CODE, 8'h00);
        write_reg(msp_pkg::REG_SYSEX_MODE, {6'd0, msp_pkg::MODE_STEP});
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h55);
        send_byte(8'h2a);
        send_byte(8'h01);
        send_byte(8'h40);
        send_byte(8'h7f);
        send_byte(8'h55);
        wait_drained();

        write_reg(msp_pkg::REG_START_CODE, msp_pkg::START_CODE_RESET);
        write_reg(msp_pkg::REG_SYSEX_MODE, {6'd0, msp_pkg::MODE_PATTERN});
        send_byte(msp_pkg::START_CODE_RESET);
        send_byte(8'h7f);
        send_byte(8'h00);
        send_byte(8'h90);
        send_byte(8'h3c);
        send_byte(8'h7f);
        send_byte(8'h00);
        send_byte(8'h40);
        send_byte(msp_pkg::BYTE_MASK);
        send_byte(8'h00);
        send_byte(8'h7f);
        // leave a half message pending, then make its status the start code
        send_byte(8'h90);
        send_byte(8'h12);
        wait_drained();

        write_reg(msp_pkg::REG_START_CODE, 8'h90);
        send_byte(8'h05);
        wait_drained();

        write_reg(msp_pkg::REG_START_CODE, msp_pkg::STATUS_FLAG);
        write_reg(msp_pkg::REG_SYSEX_MODE, {6'd0, msp_pkg::MODE_MAIN});
        write_reg(REG_SPARE_LO, 8'h00);
        write_reg(REG_SPARE_HI, msp_pkg::BYTE_MASK);
        send_byte(msp_pkg::STATUS_FLAG);
        send_byte(8'h7f);
        send_byte(8'h7f);
        send_byte(8'h7f);
        wait_drained();

        write_reg(msp_pkg::REG_SYSEX_MODE, {6'd0, msp_pkg::MODE_DROP});
        write_reg(msp_pkg::REG_START_CODE, msp_pkg::BYTE_MASK);
        send_byte(msp_pkg::BYTE_MASK);
        send_byte(8'h11);
        send_byte(8'h22);
        wait_drained();

        random_base = bytes_queued;
        while (bytes_queued - random_base < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) < 7)
                write_reg(msp_pkg::REG_SYSEX_MODE, {6'd0, 2'($urandom_range(3))});
            if ($urandom_range(9) < 6)
                write_reg(msp_pkg::REG_START_CODE, pick_start_code());
            if ($urandom_range(19) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                          8'($urandom_range(255)));
            repeat ($urandom_range(5, 25)) push_sequence();
            wait_drained();
        end

        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
